// File: rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and helpers for the hex escape decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  // width of the per-string output counter
  localparam int COUNT_BITS = 16;
  localparam int LIMIT_W    = 16;
  localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  // decoded bytes one input word can give
  localparam int NUM_SLOTS = 3;
  localparam int SLOT_W    = 2;

  // decoupling queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [LIMIT_W-1:0]    lim_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;

  localparam cmp_t CNT_MAX     = cmp_t'((64'd1 << COUNT_BITS) - 64'd1);
  localparam lim_t LIMIT_RESET = '1;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_X     = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  // one decoded group handed from front to back
  typedef struct packed {
    logic [NUM_SLOTS-1:0][7:0] data;
    slot_t                     cnt;
    logic                      last;
  } job_t;

  function automatic logic is_hex(input logic [7:0] b);
    logic res;
    res = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
          ((b >= 8'h61) && (b <= 8'h66));
    return res;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      v = b - 8'h30;
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b - 8'h37;
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// File: rtl/hed_ifs.sv
// ----------------------------------------------------------------------------
// hed channel interfaces
// Valid/ready channels for input bytes, decoded results and configuration.
// ----------------------------------------------------------------------------
interface hed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface hed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_string;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_string, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_string, output ready);
endinterface

interface hed_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] output_limit;

  modport source (output valid, output output_limit, input ready);
  modport sink   (input valid, input output_limit, output ready);
endinterface

// File: rtl/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Escape phase machine: classifies each input word, applies the output limit
// and hands groups of up to three decoded bytes to the queue.
// ----------------------------------------------------------------------------
module hed_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  hed_pkg::lim_t       cfg_limit,
  output logic                push_valid,
  input  logic                push_ready,
  output hed_pkg::job_t       push_job
);

  hed_pkg::phase_t  phase_r, phase_nxt, step_phase;
  logic [7:0]       held_r, held_nxt, step_held;
  hed_pkg::cnt_t    count_r, count_nxt;
  hed_pkg::lim_t    limit_r, limit_nxt;

  logic [hed_pkg::NUM_SLOTS-1:0][7:0] slots;
  hed_pkg::slot_t   n;
  hed_pkg::slot_t   kept;
  hed_pkg::cmp_t    limit_eff;
  hed_pkg::cmp_t    room;
  logic             accept;
  logic             b_hex;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;
  assign accept    = in_valid && push_ready;
  assign b_hex     = hed_pkg::is_hex(in_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hed_pkg::PH_IDLE;
      held_r  <= '0;
      count_r <= '0;
      limit_r <= hed_pkg::LIMIT_RESET;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      limit_r <= limit_nxt;
    end
  end

  // phase step for the current word
  always_comb begin
    step_phase = phase_r;
    step_held  = held_r;
    slots      = '0;
    n          = '0;
    unique case (phase_r)
      hed_pkg::PH_IDLE: begin
        if (in_byte == hed_pkg::CH_BACKSLASH) begin
          step_phase = hed_pkg::PH_ESC;
        end else begin
          slots[0] = in_byte;
          n        = 2'd1;
        end
      end
      hed_pkg::PH_ESC: begin
        if (in_byte == hed_pkg::CH_X) begin
          step_phase = hed_pkg::PH_X;
        end else begin
          slots[0]   = in_byte;
          n          = 2'd1;
          step_phase = hed_pkg::PH_IDLE;
        end
      end
      hed_pkg::PH_X: begin
        if (b_hex) begin
          step_held  = in_byte;
          step_phase = hed_pkg::PH_DIGIT;
        end else begin
          // broken escape: the x falls back, this byte decodes anew
          slots[0] = hed_pkg::CH_X;
          if (in_byte == hed_pkg::CH_BACKSLASH) begin
            step_phase = hed_pkg::PH_ESC;
            n          = 2'd1;
          end else begin
            slots[1]   = in_byte;
            n          = 2'd2;
            step_phase = hed_pkg::PH_IDLE;
          end
        end
      end
      hed_pkg::PH_DIGIT: begin
        if (b_hex) begin
          slots[0]   = {hed_pkg::hex_value(held_r), hed_pkg::hex_value(in_byte)};
          n          = 2'd1;
          step_phase = hed_pkg::PH_IDLE;
        end else begin
          slots[0] = hed_pkg::CH_X;
          slots[1] = held_r;
          if (in_byte == hed_pkg::CH_BACKSLASH) begin
            step_phase = hed_pkg::PH_ESC;
            n          = 2'd2;
          end else begin
            slots[2]   = in_byte;
            n          = 2'd3;
            step_phase = hed_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        step_phase = hed_pkg::PH_IDLE;
      end
    endcase

    // flush whatever escape is pending at the end of the string
    if (in_last) begin
      unique case (step_phase)
        hed_pkg::PH_ESC: begin
          slots[n] = hed_pkg::CH_BACKSLASH;
          n        = n + 2'd1;
        end
        hed_pkg::PH_X: begin
          slots[0] = hed_pkg::CH_X;
          n        = 2'd1;
        end
        hed_pkg::PH_DIGIT: begin
          slots[0] = hed_pkg::CH_X;
          slots[1] = step_held;
          n        = 2'd2;
        end
        default: begin
        end
      endcase
      step_phase = hed_pkg::PH_IDLE;
      step_held  = '0;
    end
  end

  // output limit: keep only what still fits
  always_comb begin
    limit_eff = (hed_pkg::cmp_t'(limit_r) > hed_pkg::CNT_MAX) ?
                hed_pkg::CNT_MAX : hed_pkg::cmp_t'(limit_r);
    room = (hed_pkg::cmp_t'(count_r) < limit_eff) ?
           (limit_eff - hed_pkg::cmp_t'(count_r)) : '0;
    kept = (room >= hed_pkg::cmp_t'(n)) ? n : room[hed_pkg::SLOT_W-1:0];
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    count_nxt = count_r;
    limit_nxt = limit_r;
    if (accept) begin
      phase_nxt = step_phase;
      held_nxt  = step_held;
      count_nxt = in_last ? '0 : (count_r + hed_pkg::cnt_t'(kept));
    end
    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_limit;
    end
  end

  assign push_valid     = in_valid && ((kept != '0) || in_last);
  assign push_job.data  = slots;
  assign push_job.cnt   = kept;
  assign push_job.last  = in_last;

endmodule

// File: rtl/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue
// Small FIFO of decoded groups between the front and back parts.
// ----------------------------------------------------------------------------
module hed_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  hed_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop,
  output hed_pkg::job_t pop_job
);

  hed_pkg::job_t  slots_r [hed_pkg::QDEPTH];
  hed_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  hed_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  hed_pkg::qcnt_t fill_r, fill_nxt;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill_r != hed_pkg::qcnt_t'(hed_pkg::QDEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_job    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? (wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? (rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Walks each queued group one byte per cycle into the output register while the receiver takes each word.
// ----------------------------------------------------------------------------
module hed_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  hed_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          end_of_string
);

  hed_pkg::slot_t idx_r, idx_nxt;
  logic           ov_r, ov_nxt;
  logic [7:0]     byte_r;
  logic           bvalid_r;
  logic           eos_r;
  hed_pkg::slot_t last_idx;
  logic           final_word;
  logic           load;

  // empty group only exists for an end-of-string marker
  assign last_idx   = (job.cnt == '0) ? '0 : (job.cnt - 1'b1);
  assign final_word = (idx_r == last_idx);
  assign load       = job_valid && (!ov_r || out_ready);
  assign job_pop    = load && final_word;

  always_comb begin
    ov_nxt  = ov_r;
    idx_nxt = idx_r;
    if (load) begin
      ov_nxt  = 1'b1;
      idx_nxt = final_word ? '0 : (idx_r + 1'b1);
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= (job.cnt == '0) ? 8'h00 : job.data[idx_r];
      bvalid_r <= (job.cnt != '0);
      eos_r    <= job.last && final_word;
    end
  end

  assign out_valid     = ov_r;
  assign out_byte      = byte_r;
  assign byte_valid    = bvalid_r;
  assign end_of_string = eos_r;

endmodule

// File: rtl/hex_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// hex_escape_decoder_unit
// Backslash / hex escape decoder for byte strings.
// ----------------------------------------------------------------------------
// in_if takes one raw byte per word, with in_last on the final byte of a
// string. out_if gives one decoded byte per word; the last word caused by
// the final input byte has end_of_string set, and a string whose end gives
// no kept byte ends with a single word with byte_valid low and byte zero.
// cfg_if writes output_limit, the most decoded bytes kept per string; it is
// always ready and should be written while no string is in flight.
// The front phase machine takes one input byte per cycle while the queue has
// room and pushes a group of up to three decoded bytes into a four-entry
// queue; the back part drains one output word per cycle into the output
// register while the receiver is ready. The group of an accepted input byte
// is written to the queue, then its first byte to the output register.
// Throughput is one byte per cycle while nothing stalls; an input byte that
// falls back an escape gives up to three output words, and the queue absorbs short bursts of these.
// Reset clears the escape phase, the output count and the queue, and sets
// output_limit to 65535. When the receiver stalls, the output word holds,
// the queue fills and in_if.ready drops once it holds four groups.
// ----------------------------------------------------------------------------
module hex_escape_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  hed_in_if.sink     in_if,
  hed_out_if.source  out_if,
  hed_cfg_if.sink    cfg_if
);

  logic          push_valid;
  logic          push_ready;
  hed_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop;
  hed_pkg::job_t pop_job;

  hed_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_byte    (in_if.in_byte),
    .in_last    (in_if.in_last),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_limit  (cfg_if.output_limit),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  hed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_job    (pop_job)
  );

  hed_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (pop_valid),
    .job           (pop_job),
    .job_pop       (pop),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_byte      (out_if.out_byte),
    .byte_valid    (out_if.byte_valid),
    .end_of_string (out_if.end_of_string)
  );

endmodule

// File: rtl/hed_checker.sv
// ----------------------------------------------------------------------------
// hed_checker
// Port-level checks for the hex escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hed_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       end_of_string
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(byte_valid) && $stable(end_of_string))
    else $error("stalled output word changed");

  // a word without a byte only marks the end of a string
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> end_of_string && (out_byte == 8'h00))
    else $error("empty word without end of string");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // queue is empty after reset, so input is taken at once
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind hex_escape_decoder_unit hed_checker u_hed_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_byte      (out_if.out_byte),
  .byte_valid    (out_if.byte_valid),
  .end_of_string (out_if.end_of_string)
);
